// File: src/sed_pkg.sv
// shared types, codes and helpers for the soh/eot checksum deframer
// no dependencies; imported by every module of the block
`default_nettype none
package sed_pkg;

	localparam logic [7:0] SOH_CODE = 8'h01;
	localparam logic [7:0] EOT_CODE = 8'h04;
	localparam logic [7:0] PROTO_ID = 8'h4E;
	localparam logic [2:0] COUNT_MAX = 3'd4;

	localparam logic ITEM_PAYLOAD = 1'b0;
	localparam logic ITEM_STATUS  = 1'b1;

	localparam logic [1:0] STATUS_GOOD      = 2'd0;
	localparam logic [1:0] STATUS_CHECKSUM  = 2'd1;
	localparam logic [1:0] STATUS_PROTO     = 2'd2;
	localparam logic [1:0] STATUS_TOO_SHORT = 2'd3;

	typedef struct packed {
		logic       item_kind;
		logic [7:0] payload_byte;
		logic [1:0] frame_status;
	} result_t;

	// upper-case ascii hex digit for one nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10)
			c = 8'h30 + {4'd0, nib};
		else
			c = 8'h41 + {4'd0, nib} - 8'd10;
		return c;
	endfunction

endpackage
`default_nettype wire

// File: src/soh_eot_checksum_deframer_core.sv
// top level of the soh/eot checksum deframer: input register, frame logic, output register
// depends on sed_pkg, sed_frame_ctl and sed_out_reg
//
// usage: link bytes enter on rx_byte with in_valid/in_ready; results leave on
// item_kind, payload_byte and frame_status with out_valid/out_ready.
// every accepted byte updates the frame state and yields zero or one result:
// a payload byte (body bytes from the third up to the checksum) or, at eot
// inside a frame, one status transaction (good, checksum, protocol id, short).
// a result goes through the input register, then the output register, to out_valid.
// throughput: one byte per cycle while out_ready stays high; the input and output
// registers each hold one transaction, so a new byte is taken while a result waits.
// when out_ready is low and a result is pending, the byte in the input stage
// waits and in_ready drops once that stage is full.
// reset clears the frame state (no frame open) and empties both stages.
`default_nettype none
module soh_eot_checksum_deframer_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            item_kind,
	output logic [7:0]      payload_byte,
	output logic [1:0]      frame_status
);
	import sed_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       out_free;
	logic       adv;
	logic       res_valid;
	result_t    res;
	result_t    res_q;

	assign adv      = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			rx_byte_s1 <= rx_byte;
	end

	sed_frame_ctl u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.rx_byte_s1 (rx_byte_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	sed_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && res_valid),
		.res       (res),
		.free      (out_free),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign item_kind    = res_q.item_kind;
	assign payload_byte = res_q.payload_byte;
	assign frame_status = res_q.frame_status;

endmodule
`default_nettype wire

// File: src/sed_frame_ctl.sv
// frame tracking state, two-byte checksum delay and result generation
// depends on sed_pkg
`default_nettype none
module sed_frame_ctl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic [7:0]      rx_byte_s1,
	output logic                 res_valid,
	output sed_pkg::result_t     res
);
	import sed_pkg::*;

	logic       in_frame_q;
	logic [7:0] body_sum_q;
	logic [7:0] hold_near_q;
	logic [7:0] hold_far_q;
	logic [2:0] byte_count_q;
	logic [7:0] first_byte_q;

	logic       is_soh;
	logic       is_eot;
	logic [7:0] chk;
	logic [1:0] status;

	assign is_soh = (rx_byte_s1 == SOH_CODE);
	assign is_eot = (rx_byte_s1 == EOT_CODE);
	assign chk    = 8'h00 - body_sum_q;

	always_comb begin
		if (byte_count_q < COUNT_MAX)
			status = STATUS_TOO_SHORT;
		else if (hold_far_q != hex_char(chk[7:4]) || hold_near_q != hex_char(chk[3:0]))
			status = STATUS_CHECKSUM;
		else if (first_byte_q != PROTO_ID)
			status = STATUS_PROTO;
		else
			status = STATUS_GOOD;
	end

	assign res_valid = !is_soh && in_frame_q && (is_eot || byte_count_q == COUNT_MAX);

	always_comb begin
		if (is_eot) begin
			res.item_kind    = ITEM_STATUS;
			res.payload_byte = 8'h00;
			res.frame_status = status;
		end else begin
			res.item_kind    = ITEM_PAYLOAD;
			res.payload_byte = hold_far_q;
			res.frame_status = STATUS_GOOD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			body_sum_q   <= 8'h00;
			hold_near_q  <= 8'h00;
			hold_far_q   <= 8'h00;
			byte_count_q <= 3'd0;
			first_byte_q <= 8'h00;
		end else if (en) begin
			if (is_soh || (in_frame_q && is_eot)) begin
				in_frame_q   <= is_soh;
				body_sum_q   <= 8'h00;
				hold_near_q  <= 8'h00;
				hold_far_q   <= 8'h00;
				byte_count_q <= 3'd0;
				first_byte_q <= 8'h00;
			end else if (in_frame_q) begin
				if (byte_count_q == 3'd0)
					first_byte_q <= rx_byte_s1;
				if (byte_count_q >= 3'd2)
					body_sum_q <= body_sum_q + hold_far_q;
				hold_far_q  <= hold_near_q;
				hold_near_q <= rx_byte_s1;
				if (byte_count_q < COUNT_MAX)
					byte_count_q <= byte_count_q + 3'd1;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/sed_out_reg.sv
// output result register with valid/ready handshake
// depends on sed_pkg
`default_nettype none
module sed_out_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire sed_pkg::result_t res,
	output logic                 free,
	input  wire logic            out_ready,
	output logic                 out_valid,
	output sed_pkg::result_t     res_q
);
	import sed_pkg::*;

	logic out_valid_q;

	assign free      = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

endmodule
`default_nettype wire

// File: tb/soh_eot_checksum_deframer_core_tb.sv
// self-checking testbench for soh_eot_checksum_deframer_core: link bytes in, payload and
// frame status out, both sides with valid/ready and random idling
// depends on sed_pkg and the core; keeps its own copy of the frame state to predict results
`timescale 1ns / 100ps
module soh_eot_checksum_deframer_core_tb;
	import sed_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int RANDOM_BYTES = 1200;
	localparam int DRAIN_LIMIT  = 1000;

	typedef logic [7:0] lead_bytes_t[$];

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       item_kind;
	logic [7:0] payload_byte;
	logic [1:0] frame_status;

	// predicted frame state
	logic       frm_open;
	logic [7:0] frm_sum;
	logic [7:0] frm_near;
	logic [7:0] frm_far;
	logic [2:0] frm_count;
	logic [7:0] frm_proto;

	result_t expected_results[$];
	int      err_count = 0;
	int      cycle_count = 0;
	int      bytes_sent = 0;
	bit      in_stall_en = 1'b1;
	bit      out_stall_en = 1'b1;

	soh_eot_checksum_deframer_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.item_kind   (item_kind),
		.payload_byte(payload_byte),
		.frame_status(frame_status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("soh_eot_checksum_deframer_core_tb: FAIL");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= !out_stall_en || ($urandom_range(99) >= 26);

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected transaction: item_kind %0d payload_byte %h frame_status %0d",
					item_kind, payload_byte, frame_status);
				err_count++;
			end else begin
				want = expected_results.pop_front();
				if (item_kind !== want.item_kind) begin
					$error("item_kind: expected %0d, actual %0d", want.item_kind, item_kind);
					err_count++;
				end
				if (payload_byte !== want.payload_byte) begin
					$error("payload_byte: expected %h, actual %h",
						want.payload_byte, payload_byte);
					err_count++;
				end
				if (frame_status !== want.frame_status) begin
					$error("frame_status: expected %0d, actual %0d",
						want.frame_status, frame_status);
					err_count++;
				end
			end
		end
	end

	function automatic logic [7:0] asc_hex(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
	endfunction

	function automatic void clear_frame_state();
		frm_sum   = 8'h00;
		frm_near  = 8'h00;
		frm_far   = 8'h00;
		frm_count = 3'd0;
		frm_proto = 8'h00;
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		logic [7:0] chk;
		logic [1:0] st;
		if (b == SOH_CODE) begin
			clear_frame_state();
			frm_open = 1'b1;
		end else if (frm_open && b == EOT_CODE) begin
			chk = 8'h00 - frm_sum;
			if (frm_count < COUNT_MAX)
				st = STATUS_TOO_SHORT;
			else if (frm_far != asc_hex(chk[7:4]) || frm_near != asc_hex(chk[3:0]))
				st = STATUS_CHECKSUM;
			else if (frm_proto != PROTO_ID)
				st = STATUS_PROTO;
			else
				st = STATUS_GOOD;
			expected_results.push_back('{ITEM_STATUS, 8'h00, st});
			frm_open = 1'b0;
			clear_frame_state();
		end else if (frm_open) begin
			if (frm_count == 3'd0)
				frm_proto = b;
			if (frm_count >= 3'd2)
				frm_sum = frm_sum + frm_far;
			if (frm_count >= COUNT_MAX)
				expected_results.push_back('{ITEM_PAYLOAD, frm_far, STATUS_GOOD});
			frm_far  = frm_near;
			frm_near = b;
			if (frm_count < COUNT_MAX)
				frm_count = frm_count + 3'd1;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while (in_stall_en && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		deframe_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// frame with the checksum characters appended, optionally with one checksum bit flipped
	task automatic send_frame(input lead_bytes_t lead, input bit bad_sum);
		logic [7:0] s;
		logic [7:0] c;
		s = 8'h00;
		foreach (lead[i])
			s = s + lead[i];
		c = 8'h00 - s;
		if (bad_sum)
			c = c ^ (8'h01 << $urandom_range(7));
		send_byte(SOH_CODE);
		foreach (lead[i])
			send_byte(lead[i]);
		send_byte(asc_hex(c[7:4]));
		send_byte(asc_hex(c[3:0]));
		send_byte(EOT_CODE);
	endtask

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == SOH_CODE || b == EOT_CODE);
		return b;
	endfunction

	task automatic send_random_frame();
		lead_bytes_t lead;
		int          len;
		int          pick;
		logic [7:0]  b;
		pick = $urandom_range(99);
		if (pick < 80) begin
			len = ($urandom_range(99) < 85) ? $urandom_range(2, 10) : $urandom_range(0, 40);
			for (int i = 0; i < len; i++)
				lead.push_back((i == 0 && $urandom_range(99) < 85) ? PROTO_ID : body_byte());
			send_frame(lead, $urandom_range(99) < 20);
		end else if (pick < 90) begin
			// frame left open, the next soh restarts it
			send_byte(SOH_CODE);
			len = $urandom_range(0, 8);
			for (int i = 0; i < len; i++)
				send_byte(body_byte());
		end else begin
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				pick = $urandom_range(99);
				b = (pick < 15) ? EOT_CODE : (pick < 25) ? SOH_CODE : 8'($urandom);
				send_byte(b);
			end
		end
	endtask

	task automatic test_outside_frame();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(EOT_CODE);
	endtask

	task automatic test_restart_and_short();
		send_byte(SOH_CODE);
		send_byte(PROTO_ID);
		send_byte(8'h80);
		send_byte(SOH_CODE);
		send_byte(EOT_CODE);
	endtask

	task automatic test_good_frame();
		send_frame('{PROTO_ID, 8'hFF}, 1'b0);
	endtask

	task automatic test_fault_priority();
		send_frame('{8'h00, 8'h7F}, 1'b1);
		send_frame('{8'h4F, 8'h05}, 1'b0);
	endtask

	task automatic test_burst_no_idle();
		in_stall_en  = 1'b0;
		out_stall_en = 1'b0;
		repeat (25)
			send_random_frame();
		in_stall_en  = 1'b1;
		out_stall_en = 1'b1;
	endtask

	task automatic test_random_frames(input int target);
		while (bytes_sent < target)
			send_random_frame();
	endtask

	initial begin
		frm_open = 1'b0;
		clear_frame_state();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_outside_frame();
		test_restart_and_short();
		test_good_frame();
		test_fault_priority();
		test_burst_no_idle();
		test_random_frames(RANDOM_BYTES);
		in_valid <= 1'b0;
		for (int k = 0; k < DRAIN_LIMIT && expected_results.size() != 0; k++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected transactions never arrived", expected_results.size());
			err_count++;
		end
		if (err_count == 0)
			$display("soh_eot_checksum_deframer_core_tb: PASS");
		else
			$display("soh_eot_checksum_deframer_core_tb: FAIL");
		$finish;
	end

endmodule

// File: sim.f
src/sed_pkg.sv
src/sed_frame_ctl.sv
src/sed_out_reg.sv
src/soh_eot_checksum_deframer_core.sv
tb/soh_eot_checksum_deframer_core_tb.sv
